// File: sv/stil_pkg.sv
// ----------------------------------------------------------------------------
// stil_pkg: shared types and constants of the sorted total insert list
// Entry layout, handshake field widths, result kinds and sequencer states.
// ----------------------------------------------------------------------------
package stil_pkg;

    localparam int DEPTH     = 16;
    localparam int MAX_ITEMS = 128;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PTR_W   = $clog2(DEPTH + 1);

    localparam int PRICE_W = 24;
    localparam int TAG_W   = 16;
    localparam int TOTAL_W = 32;
    localparam int COUNT_W = 8;
    localparam int RANK_W  = 5;
    localparam int KIND_W  = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_DUMP = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
    } acc_t;

    typedef struct packed {
        logic add;
        logic last;
    } acc_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_WR,
        ST_DUMP,
        ST_EMPTY
    } state_t;

endpackage

// File: sv/stil_ram.sv
// ----------------------------------------------------------------------------
// stil_ram: simple dual-port RAM
// One write port, one read port with registered data and a read enable.
// ----------------------------------------------------------------------------
module stil_ram #(
    parameter int  DEPTH = 16,
    parameter int  WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/stil_accum.sv
// ----------------------------------------------------------------------------
// stil_accum: running record accumulator
// Saturating price sum and item count; presents the sum including the
// current beat and restarts at zero after a record's last item.
// ----------------------------------------------------------------------------
module stil_accum (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  stil_pkg::acc_ctl_t             ctl,
    input  logic [stil_pkg::PRICE_W-1:0]   price,
    output stil_pkg::acc_t                 sum
);
    import stil_pkg::*;

    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TOTAL_W:0]   wide_sum;

    always_comb begin
        wide_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(price);
        sum.total = wide_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : wide_sum[TOTAL_W-1:0];
        sum.count = (count_reg < COUNT_W'(MAX_ITEMS)) ? count_reg + COUNT_W'(1)
                                                      : count_reg;
    end

    always_comb begin
        total_next = total_reg;
        count_next = count_reg;
        if (ctl.add) begin
            if (ctl.last) begin
                total_next = '0;
                count_next = '0;
            end else begin
                total_next = sum.total;
                count_next = sum.count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            count_reg <= '0;
        end else begin
            total_reg <= total_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/stil_seq.sv
// ----------------------------------------------------------------------------
// stil_seq: store sequencer
// Walks the sorted store for inserts and dumps and drives the result
// register.
// ----------------------------------------------------------------------------
module stil_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          func,
    input  logic                          last_item,
    input  logic [stil_pkg::TAG_W-1:0]    order_tag,
    input  stil_pkg::acc_t                rec,
    output logic                          ram_wr_en,
    output logic [stil_pkg::ADDR_W-1:0]   ram_wr_addr,
    output stil_pkg::entry_t              ram_wr_data,
    output logic                          ram_rd_en,
    output logic [stil_pkg::ADDR_W-1:0]   ram_rd_addr,
    input  stil_pkg::entry_t              ram_rd_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stil_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [stil_pkg::KIND_W-1:0]   m_tuser,
    output logic                          m_tlast
);
    import stil_pkg::*;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   occ_reg, occ_next;
    logic [PTR_W-1:0]   j_reg, j_next;
    entry_t             rec_reg, rec_next;

    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [RANK_W-1:0]  out_rank_reg, out_rank_next;
    entry_t             out_ent_reg, out_ent_next;
    logic               out_drop_reg, out_drop_next;
    logic               out_last_reg, out_last_next;
    logic               out_load;

    logic               accept;
    logic               slot_free;
    logic               full;
    logic               smaller;
    logic               at_top;
    logic               last_entry;

    assign slot_free  = !out_valid_reg || m_tready;
    assign full       = (occ_reg == PTR_W'(DEPTH));
    assign smaller    = (rec_reg.total < ram_rd_data.total);
    assign at_top     = (j_reg == PTR_W'(1));
    assign last_entry = ((j_reg + PTR_W'(1)) == occ_reg);
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (func == FUNC_DUMP) begin
                        state_next = (occ_reg == '0) ? ST_EMPTY : ST_DUMP;
                    end else if (last_item) begin
                        state_next = (occ_reg == '0) ? ST_WR : ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                if (smaller || at_top) begin
                    state_next = ST_WR;
                end
            end
            ST_WR: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (slot_free && last_entry) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        occ_next      = occ_reg;
        j_next        = j_reg;
        rec_next      = rec_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = j_reg[ADDR_W-1:0];
        ram_wr_data   = ram_rd_data;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = '0;
        out_load      = 1'b0;
        out_kind_next = KIND_ACK;
        out_rank_next = RANK_W'(j_reg);
        out_ent_next  = rec_reg;
        out_drop_next = 1'b0;
        out_last_next = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (func == FUNC_DUMP) begin
                        j_next    = '0;
                        ram_rd_en = (occ_reg != '0);
                    end else if (last_item) begin
                        rec_next.total = rec.total;
                        rec_next.tag   = order_tag;
                        rec_next.count = rec.count;
                        j_next         = occ_reg;
                        ram_rd_en      = (occ_reg != '0);
                        ram_rd_addr    = ADDR_W'(occ_reg - PTR_W'(1));
                    end
                end
            end
            ST_CMP: begin
                // shift the entry one slot down unless it falls off the end
                if (!smaller) begin
                    ram_wr_en = (j_reg < PTR_W'(DEPTH));
                    j_next    = j_reg - PTR_W'(1);
                    if (!at_top) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(j_reg - PTR_W'(2));
                    end
                end
            end
            ST_WR: begin
                if (slot_free) begin
                    ram_wr_en     = (j_reg < PTR_W'(DEPTH));
                    ram_wr_data   = rec_reg;
                    out_load      = 1'b1;
                    out_drop_next = full;
                    occ_next      = full ? occ_reg : occ_reg + PTR_W'(1);
                end
            end
            ST_DUMP: begin
                if (slot_free) begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_ENTRY;
                    out_ent_next  = ram_rd_data;
                    out_last_next = last_entry;
                    if (!last_entry) begin
                        j_next      = j_reg + PTR_W'(1);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(j_reg + PTR_W'(1));
                    end
                end
            end
            ST_EMPTY: begin
                if (slot_free) begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_EMPTY;
                    out_rank_next = '0;
                    out_ent_next  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            j_reg     <= j_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
        if (out_load) begin
            out_kind_reg <= out_kind_next;
            out_rank_reg <= out_rank_next;
            out_ent_reg  <= out_ent_next;
            out_drop_reg <= out_drop_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_drop_reg, out_ent_reg.count, out_ent_reg.tag,
                       out_ent_reg.total, out_rank_reg};

endmodule

// File: sv/sorted_total_insert_list_unit.sv
// ----------------------------------------------------------------------------
// sorted_total_insert_list_unit: sorted record store with price accumulation
// Sums price beats into records and keeps the records in a memory sorted by
// descending total; dumps the store on command.
// ----------------------------------------------------------------------------
// A price beat (s_tuser = 0) adds its price to the running record; the beat
// with s_tlast set closes the record and inserts it, ahead of any equal
// totals, into a 16-entry store sorted by descending total. A non-final
// price beat produces nothing. An insert walks the store upward from its
// bottom through a single-read-port memory, one entry per cycle. A record
// holds the input off while it walks the store and is written, and its
// acknowledge beat (kind 0) is presented once it is written. A full store
// drops its smallest entry and flags it. A dump beat (s_tuser = 1) holds
// the input off until the last stored entry is loaded for output, one
// memory read per result beat; the first entry is read as the dump is taken
// and then loaded into the result register. On an empty store a dump yields
// one marker beat (kind 2). A pending result that waits on m_tready holds
// the insert or dump back. The result register lets the last result wait on
// m_tready while the next beat is taken. Stored entries are only ever read
// below the fill count, so the memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module sorted_total_insert_list_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [23:0] price, [39:24] order_tag
    input  logic [stil_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] func
    input  logic [0:0]                      s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [4:0] rank, [36:5] order_total, [52:37] tag_out, [60:53] item_count,
    // [61] dropped, [63:62] zero
    output logic [stil_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] kind
    output logic [stil_pkg::KIND_W-1:0]     m_tuser,
    output logic                            m_tlast
);
    import stil_pkg::*;

    acc_ctl_t              acc_ctl;
    acc_t                  acc_sum;
    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    entry_t                ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [ENTRY_W-1:0]    ram_rd_bits;
    entry_t                ram_rd_data;

    // advance the running record only on accepted price beats
    assign acc_ctl.add  = s_tvalid && s_tready && (s_tuser[0] == FUNC_ADD);
    assign acc_ctl.last = s_tlast;
    assign ram_rd_data  = entry_t'(ram_rd_bits);

    stil_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .price   (s_tdata[PRICE_W-1:0]),
        .sum     (acc_sum)
    );

    stil_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_bits)
    );

    stil_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .func        (s_tuser[0]),
        .last_item   (s_tlast),
        .order_tag   (s_tdata[PRICE_W +: TAG_W]),
        .rec         (acc_sum),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// File: sv/stil_checker.sv
// ----------------------------------------------------------------------------
// stil_checker: port-level checks of the sorted total insert list
// Watches the top-level handshakes and result beats over time.
// ----------------------------------------------------------------------------
module stil_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [stil_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [stil_pkg::KIND_W-1:0]     m_tuser,
    input  logic                            m_tlast
);
    import stil_pkg::*;

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                   && $stable(m_tlast))
        else $error("stalled result beat changed");

    // a dump keeps the input held off in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == FUNC_DUMP) |=> !s_tready)
        else $error("input taken during dump");

    // acknowledge closes its run and its rank is at most the store depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ACK) |->
            m_tlast && (m_tdata[RANK_W-1:0] <= RANK_W'(DEPTH)))
        else $error("bad acknowledge beat");

    // empty marker is a single all-zero beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_EMPTY) |-> m_tlast && (m_tdata == '0))
        else $error("bad empty marker");

endmodule

bind sorted_total_insert_list_unit stil_checker u_stil_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
